[rtl/rh_pkg.sv]
`default_nettype none

package rh_pkg;

	localparam int DEF_MAX_PATTERN = 256;
	localparam int DEF_MAX_TEXT    = 4096;

	localparam int BYTE_W  = 8;
	localparam int HASH_W  = 9;
	localparam int Q_W     = 8;
	localparam int LEN_W   = 9;
	localparam int START_W = 12;

	// dividend of the remainder unit: (hash - old*power)*256 + byte fits in 26 bits
	localparam int DIV_W     = 26;
	localparam int MOD_STEPS = DIV_W / 2;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS        = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

	localparam logic [Q_W-1:0]   RESET_MODULUS        = 8'd101;
	localparam logic [LEN_W-1:0] RESET_PATTERN_LENGTH = 9'd4;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_CHECK,
		ST_P_POW,
		ST_P_HASH,
		ST_T_CHECK,
		ST_T_READ,
		ST_T_ROLL,
		ST_T_HASH,
		ST_V_INIT,
		ST_VERIFY,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic                    start;
		logic signed [DIV_W-1:0] dividend;
	} mod_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [HASH_W-1:0] rem;
	} mod_rsp_t;

endpackage

`default_nettype wire

[rtl/rh_if.sv]
`default_nettype none

interface rh_in_if;
	logic                               valid;
	logic                               ready;
	logic                               op;
	logic signed [rh_pkg::BYTE_W-1:0]   byte_value;
	logic                               starts_over;

	modport source(output valid, op, byte_value, starts_over, input ready);
	modport sink(input valid, op, byte_value, starts_over, output ready);
endinterface

interface rh_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [rh_pkg::HASH_W-1:0]   hash_value;
	logic [rh_pkg::START_W-1:0]         window_start;
	logic                               full_match;

	modport source(output valid, hash_value, window_start, full_match, input ready);
	modport sink(input valid, hash_value, window_start, full_match, output ready);
endinterface

interface rh_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rh_pkg::CFG_IDX_W-1:0]       index;
	logic [rh_pkg::CFG_DATA_W-1:0]      data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/rh_mod_unit.sv]
`default_nettype none

// Truncating signed remainder by q, two quotient bits per cycle.
module rh_mod_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rh_pkg::mod_req_t          req,
	input  logic [rh_pkg::Q_W-1:0]    q,
	output rh_pkg::mod_rsp_t          rsp
);
	import rh_pkg::*;

	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_W-1:0]     mag_q;
	logic [Q_W-1:0]       r_q;

	logic [DIV_W-1:0]     mag_in;
	logic [Q_W:0]         t1;
	logic [Q_W:0]         t2;
	logic [Q_W-1:0]       r1;
	logic [Q_W-1:0]       r2;
	logic signed [HASH_W-1:0] rem_pos;

	assign mag_in = req.dividend[DIV_W-1] ? (~req.dividend + 1'b1) : req.dividend;

	always_comb begin
		t1 = {r_q, mag_q[DIV_W-1]};
		if (t1 >= {1'b0, q}) begin
			t1 = t1 - {1'b0, q};
		end
		r1 = t1[Q_W-1:0];
		t2 = {r1, mag_q[DIV_W-2]};
		if (t2 >= {1'b0, q}) begin
			t2 = t2 - {1'b0, q};
		end
		r2 = t2[Q_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= MOD_CNT_W'(MOD_STEPS);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == MOD_CNT_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[DIV_W-1];
			mag_q <= mag_in;
			r_q   <= '0;
		end else if (cnt_q != '0) begin
			mag_q <= mag_q << 2;
			r_q   <= r2;
		end
	end

	assign rem_pos  = $signed({1'b0, r_q});
	assign rsp.done = done_q;
	assign rsp.rem  = neg_q ? -rem_pos : rem_pos;

endmodule

`default_nettype wire

[rtl/rh_byte_mem.sv]
`default_nettype none

module rh_byte_mem #(
	parameter int DEPTH = rh_pkg::DEF_MAX_PATTERN,
	parameter int AW    = $clog2(rh_pkg::DEF_MAX_PATTERN)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [rh_pkg::BYTE_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [rh_pkg::BYTE_W-1:0] rdata
);
	import rh_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/rolling_hash_pattern_search.sv]
`default_nettype none

// Rolling-hash (Rabin-Karp, radix 256) pattern search over signed bytes. Pattern bytes
// (op 0) build the pattern hash and 256^(M-1) mod q; text bytes (op 1) roll the window
// hash, and a full window whose hash equals the hash of a complete pattern gives one
// result carrying the hash, the window start and a full byte compare flag. Every
// remainder goes through one shared unit that retires two bits per cycle. The first
// pattern byte needs one remainder and each later one two (power, then hash); bytes past
// M are dropped. A text byte needs one remainder while the window fills, and once it
// rolls a ring read and one 8x9 multiply come ahead of the remainder. A hash hit adds a
// byte compare, reading pattern store and window ring one byte per cycle, and then the
// load of the output register. The input is not ready while an item is in work.
module rolling_hash_pattern_search #(
	parameter int MAX_PATTERN = rh_pkg::DEF_MAX_PATTERN,
	parameter int MAX_TEXT    = rh_pkg::DEF_MAX_TEXT
) (
	input  logic     clk,
	input  logic     arst_n,
	rh_cfg_if.sink   cfg,
	rh_in_if.sink    item,
	rh_out_if.source result
);
	import rh_pkg::*;

	localparam int AW   = $clog2(MAX_PATTERN);
	localparam int MW   = $clog2(MAX_PATTERN + 1);
	localparam int TMAX = MAX_TEXT + MAX_PATTERN;
	localparam int TW   = $clog2(TMAX + 1);
	localparam int CW0  = (TW > MW) ? TW : MW;
	localparam int CW   = ((CW0 > LEN_W) ? CW0 : LEN_W) + 1;
	localparam int SW   = (CW > START_W) ? CW : START_W;
	localparam int SMAX = (MAX_TEXT - 1 > 4095) ? 4095 : MAX_TEXT - 1;

	st_t state_q, state_d;

	logic [Q_W-1:0]           modulus_q;
	logic [LEN_W-1:0]         length_q;
	logic [MW-1:0]            pcount_q;
	logic signed [HASH_W-1:0] phash_q;
	logic [Q_W-1:0]           power_q;
	logic [TW-1:0]            tcount_q;
	logic signed [HASH_W-1:0] whash_q;
	logic [AW-1:0]            head_q;
	logic signed [BYTE_W-1:0] byte_q;
	logic                     roll_q;
	logic signed [16:0]       prod_q;
	logic signed [HASH_W-1:0] hit_hash_q;
	logic [START_W-1:0]       hit_start_q;
	logic [MW-1:0]            j_q;
	logic [AW-1:0]            va_q;
	logic                     rdv_s1;
	logic                     mism_q;
	logic                     res_valid_q;
	logic signed [HASH_W-1:0] res_hash_q;
	logic [START_W-1:0]       res_start_q;
	logic                     res_full_q;

	logic [Q_W-1:0]  q_eff;
	logic [CW-1:0]   len_c;
	logic [CW-1:0]   m_c;
	logic [MW-1:0]   m_eff;
	logic [CW-1:0]   pc_c;
	logic [CW-1:0]   n_c;
	logic [MW:0]     idx_sum;
	logic [AW-1:0]   old_idx;
	logic            fill;
	logic            hit;
	logic [CW-1:0]   start_c;
	logic [SW-1:0]   start_w;
	logic [START_W-1:0] start_sat;
	logic signed [HASH_W:0]   rem_fix;
	logic signed [HASH_W-1:0] new_h;
	logic signed [DIV_W-1:0]  diff;
	logic signed [DIV_W-1:0]  pow_div;
	logic signed [DIV_W-1:0]  roll_div;
	logic                     in_xfer;
	logic                     out_load;

	mod_req_t req;
	mod_rsp_t rsp;

	logic              pat_we;
	logic              ring_we;
	logic [AW-1:0]     ring_raddr;
	logic [BYTE_W-1:0] pat_rd;
	logic [BYTE_W-1:0] ring_rd;

	function automatic logic signed [DIV_W-1:0] hash_div(
		input logic signed [HASH_W-1:0] h,
		input logic signed [BYTE_W-1:0] b
	);
		hash_div = (DIV_W'(h) <<< BYTE_W) + DIV_W'(b);
	endfunction

	// effective register values
	assign q_eff = (modulus_q < Q_W'(2)) ? Q_W'(2) : modulus_q;
	assign len_c = CW'(length_q);
	assign m_c   = (len_c == '0) ? CW'(1) :
	               (len_c > CW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : len_c;
	assign m_eff = m_c[MW-1:0];
	assign pc_c  = CW'(pcount_q);
	assign n_c   = CW'(tcount_q);
	assign fill  = (n_c < m_c);

	// ring slot M bytes behind the head
	assign idx_sum = (MW+1)'(head_q) + (MW+1)'(MAX_PATTERN) - (MW+1)'(m_eff);
	assign old_idx = (idx_sum >= (MW+1)'(MAX_PATTERN)) ?
	                 AW'(idx_sum - (MW+1)'(MAX_PATTERN)) : AW'(idx_sum);

	assign pow_div  = $signed({{(DIV_W-2*Q_W){1'b0}}, power_q, {Q_W{1'b0}}});
	assign diff     = DIV_W'(whash_q) - DIV_W'(prod_q);
	assign roll_div = (diff <<< BYTE_W) + DIV_W'(byte_q);

	assign rem_fix = HASH_W'(rsp.rem) + $signed({2'b00, q_eff});
	assign new_h   = (roll_q && rsp.rem[HASH_W-1]) ? rem_fix[HASH_W-1:0] : rsp.rem;
	assign hit     = (n_c + CW'(1) >= m_c) && (pc_c == m_c) && (phash_q == new_h);

	assign start_c   = n_c + CW'(1) - m_c;
	assign start_w   = SW'(start_c);
	assign start_sat = (start_w > SW'(SMAX)) ? START_W'(SMAX) : start_w[START_W-1:0];

	assign in_xfer  = item.valid && item.ready;
	assign out_load = (state_q == ST_EMIT) && (!res_valid_q || result.ready);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= RESET_MODULUS;
			length_q  <= RESET_PATTERN_LENGTH;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODULUS:        modulus_q <= cfg.data[Q_W-1:0];
				REG_PATTERN_LENGTH: length_q  <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_d = (item.op == OP_PATTERN) ? ST_P_CHECK : ST_T_CHECK;
				end
			end
			ST_P_CHECK: begin
				if (pc_c >= m_c) begin
					state_d = ST_IDLE;
				end else if (pcount_q != '0) begin
					state_d = ST_P_POW;
				end else begin
					state_d = ST_P_HASH;
				end
			end
			ST_P_POW: begin
				if (rsp.done) begin
					state_d = ST_P_HASH;
				end
			end
			ST_P_HASH: begin
				if (rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			ST_T_CHECK: state_d = fill ? ST_T_HASH : ST_T_READ;
			ST_T_READ:  state_d = ST_T_ROLL;
			ST_T_ROLL:  state_d = ST_T_HASH;
			ST_T_HASH: begin
				if (rsp.done) begin
					state_d = hit ? ST_V_INIT : ST_IDLE;
				end
			end
			ST_V_INIT: state_d = ST_VERIFY;
			ST_VERIFY: begin
				if (j_q == m_eff && !rdv_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!res_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item.ready   = 1'b0;
		req.start    = 1'b0;
		req.dividend = hash_div(phash_q, byte_q);
		pat_we       = 1'b0;
		ring_we      = 1'b0;
		ring_raddr   = old_idx;
		unique case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_P_CHECK: begin
				if (pc_c < m_c) begin
					pat_we    = 1'b1;
					req.start = 1'b1;
					if (pcount_q != '0) begin
						req.dividend = pow_div;
					end
				end
			end
			ST_P_POW: req.start = rsp.done;
			ST_T_CHECK: begin
				if (fill) begin
					req.start    = 1'b1;
					req.dividend = hash_div(whash_q, byte_q);
				end
			end
			ST_T_ROLL: begin
				req.start    = 1'b1;
				req.dividend = roll_div;
			end
			ST_T_HASH: ring_we = rsp.done;
			ST_VERIFY: ring_raddr = va_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pcount_q    <= '0;
			phash_q     <= '0;
			power_q     <= Q_W'(1);
			tcount_q    <= '0;
			whash_q     <= '0;
			head_q      <= '0;
			rdv_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && item.starts_over) begin
				if (item.op == OP_PATTERN) begin
					pcount_q <= '0;
					phash_q  <= '0;
					power_q  <= Q_W'(1);
				end else begin
					tcount_q <= '0;
					whash_q  <= '0;
					head_q   <= '0;
				end
			end
			if (state_q == ST_P_POW && rsp.done) begin
				power_q <= rsp.rem[Q_W-1:0];
			end
			if (state_q == ST_P_HASH && rsp.done) begin
				phash_q  <= rsp.rem;
				pcount_q <= pcount_q + 1'b1;
			end
			if (state_q == ST_T_HASH && rsp.done) begin
				whash_q <= new_h;
				head_q  <= (head_q == AW'(MAX_PATTERN - 1)) ? '0 : head_q + 1'b1;
				if (tcount_q != TW'(TMAX)) begin
					tcount_q <= tcount_q + 1'b1;
				end
			end
			rdv_s1 <= (state_q == ST_VERIFY) && (j_q != m_eff);
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_q <= item.byte_value;
		end
		if (state_q == ST_T_CHECK) begin
			roll_q <= !fill;
		end
		if (state_q == ST_T_READ) begin
			prod_q <= $signed(ring_rd) * $signed({1'b0, power_q});
		end
		if (state_q == ST_T_HASH && rsp.done) begin
			hit_hash_q  <= new_h;
			hit_start_q <= start_sat;
		end
		if (state_q == ST_V_INIT) begin
			j_q    <= '0;
			va_q   <= old_idx;
			mism_q <= 1'b0;
		end else if (state_q == ST_VERIFY) begin
			if (j_q != m_eff) begin
				j_q  <= j_q + 1'b1;
				va_q <= (va_q == AW'(MAX_PATTERN - 1)) ? '0 : va_q + 1'b1;
			end
			if (rdv_s1 && ring_rd != pat_rd) begin
				mism_q <= 1'b1;
			end
		end
		if (out_load) begin
			res_hash_q  <= hit_hash_q;
			res_start_q <= hit_start_q;
			res_full_q  <= !mism_q;
		end
	end

	rh_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q      (q_eff),
		.rsp    (rsp)
	);

	rh_byte_mem #(
		.DEPTH (MAX_PATTERN),
		.AW    (AW)
	) u_pattern_store (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pcount_q[AW-1:0]),
		.wdata (byte_q),
		.raddr (j_q[AW-1:0]),
		.rdata (pat_rd)
	);

	rh_byte_mem #(
		.DEPTH (MAX_PATTERN),
		.AW    (AW)
	) u_window_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (head_q),
		.wdata (byte_q),
		.raddr (ring_raddr),
		.rdata (ring_rd)
	);

	assign result.valid        = res_valid_q;
	assign result.hash_value   = res_hash_q;
	assign result.window_start = res_start_q;
	assign result.full_match   = res_full_q;

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !item.ready)
		else $error("input ready right after a transfer");

	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_P_POW || state_q == ST_P_HASH || state_q == ST_T_HASH))
		else $error("remainder finished outside a waiting state");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result loaded outside emit");

	a_verify_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VERIFY) |-> (j_q <= m_eff))
		else $error("compare walked past the window");

	a_emit_full_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pcount_q == m_eff))
		else $error("hit without a complete pattern");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import rh_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int IDLE_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 560;
	localparam int RADIX          = 256;
	// short text limit so the position counters saturate within the item budget
	localparam int TB_MAX_TEXT    = 256;
	localparam int COUNT_CAP      = TB_MAX_TEXT + DEF_MAX_PATTERN;
	localparam int START_CAP      = (TB_MAX_TEXT - 1 > 4095) ? 4095 : TB_MAX_TEXT - 1;
	// long enough to drive the text counter into saturation
	localparam int LONG_TEXT      = COUNT_CAP + 32;

	typedef struct packed {
		logic                     op;
		logic signed [BYTE_W-1:0] value;
		logic                     restart;
	} search_item_t;

	typedef struct packed {
		logic signed [HASH_W-1:0] hash;
		logic [START_W-1:0]       start;
		logic                     full;
	} hit_t;

	typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		search_item_t          it;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		logic                  lit;
		hit_t                  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rh_cfg_if cfg_ch();
	rh_in_if  in_ch();
	rh_out_if out_ch();

	rolling_hash_pattern_search #(
		.MAX_TEXT (TB_MAX_TEXT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (in_ch),
		.result (out_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// search state mirror
	logic [Q_W-1:0]           mod_reg;
	logic [LEN_W-1:0]         len_reg;
	logic signed [BYTE_W-1:0] pat_mem [DEF_MAX_PATTERN];
	logic signed [BYTE_W-1:0] ring_mem [DEF_MAX_PATTERN];
	int                       pat_hash;
	int                       win_hash;
	int                       pow_term;
	int                       pat_cnt;
	int                       txt_cnt;
	int                       ring_wr;

	hit_t pending_hits [$];
	hit_t want;
	int   err_cnt = 0;
	int   idle_cnt = 0;
	int   stall_left = 0;
	int   run_left = 0;
	bit   quiet = 1'b0;
	bit   busy = 1'b0;

	logic signed [BYTE_W-1:0] alpha [4];
	int                       alpha_n = 0;

	dir_row_t dir_rows [30] = '{
		// text before any pattern
		'{ROW_ITEM, '{OP_TEXT,    8'sh05, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_PATTERN, 8'sh80, 1'b1}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_PATTERN, 8'sh7f, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_PATTERN, 8'sh00, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		// window fills while the pattern is still short
		'{ROW_ITEM, '{OP_TEXT,    8'sh80, 1'b1}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh7f, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh00, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh01, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_PATTERN, 8'sh01, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		// surplus pattern byte, dropped
		'{ROW_ITEM, '{OP_PATTERN, 8'sh37, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh80, 1'b1}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh7f, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh00, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh01, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'shff, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		// q=0 runs as 2, length 0 runs as 1
		'{ROW_CFG,  '{OP_TEXT,    8'sh00, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_CFG,  '{OP_TEXT,    8'sh00, 1'b0}, REG_PATTERN_LENGTH, 9'd0, 1'b0,
			'{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_PATTERN, 8'sh00, 1'b1}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh00, 1'b1}, REG_MODULUS, 9'd0, 1'b1, '{9'sd0, 12'd0, 1'b1}},
		// hash collision, bytes differ
		'{ROW_ITEM, '{OP_TEXT,    8'sh80, 1'b0}, REG_MODULUS, 9'd0, 1'b1, '{9'sd0, 12'd1, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh7f, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_CFG,  '{OP_TEXT,    8'sh00, 1'b0}, REG_MODULUS, 9'd1, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		// length above the store size runs as 256
		'{ROW_CFG,  '{OP_TEXT,    8'sh00, 1'b0}, REG_PATTERN_LENGTH, 9'd511, 1'b0,
			'{9'sd0, 12'd0, 1'b0}},
		'{ROW_CFG,  '{OP_TEXT,    8'sh00, 1'b0}, REG_MODULUS, 9'd255, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_PATTERN, 8'sh7f, 1'b1}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'shff, 1'b1}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh7f, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		// length shrinks mid-stream, hashes kept as built
		'{ROW_CFG,  '{OP_TEXT,    8'sh00, 1'b0}, REG_PATTERN_LENGTH, 9'd1, 1'b0,
			'{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh00, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}},
		'{ROW_ITEM, '{OP_TEXT,    8'sh7f, 1'b0}, REG_MODULUS, 9'd0, 1'b0, '{9'sd0, 12'd0, 1'b0}}
	};

	function automatic bit roll_and_match(input search_item_t it, output hit_t h);
		int q;
		int m;
		int b;
		int n;
		int old;
		int t;
		int st;
		int j;
		bit full;
		q = (mod_reg < 2) ? 2 : int'(mod_reg);
		m = (len_reg == 0) ? 1 : ((len_reg > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : int'(len_reg));
		b = int'($signed(it.value));
		h = '0;
		if (it.op == OP_PATTERN) begin
			if (it.restart) begin
				pat_cnt = 0;
				pat_hash = 0;
				pow_term = 1;
			end
			if (pat_cnt >= m)
				return 1'b0;
			if (pat_cnt >= 1)
				pow_term = (pow_term * RADIX) % q;
			pat_hash = (RADIX * pat_hash + b) % q;
			pat_mem[pat_cnt] = it.value;
			pat_cnt++;
			return 1'b0;
		end
		if (it.restart) begin
			txt_cnt = 0;
			win_hash = 0;
			ring_wr = 0;
		end
		n = txt_cnt;
		if (n < m) begin
			win_hash = (RADIX * win_hash + b) % q;
		end else begin
			old = int'(ring_mem[(ring_wr + DEF_MAX_PATTERN - m) % DEF_MAX_PATTERN]);
			// % truncates toward zero, so fold a negative remainder back up
			t = (RADIX * (win_hash - old * pow_term) + b) % q;
			if (t < 0)
				t += q;
			win_hash = t;
		end
		ring_mem[ring_wr] = it.value;
		ring_wr = (ring_wr + 1) % DEF_MAX_PATTERN;
		if (txt_cnt < COUNT_CAP)
			txt_cnt++;
		if (n + 1 < m || pat_cnt != m || pat_hash != win_hash)
			return 1'b0;
		full = 1'b1;
		for (j = 0; j < m; j++) begin
			if (ring_mem[(ring_wr + DEF_MAX_PATTERN - m + j) % DEF_MAX_PATTERN] != pat_mem[j])
				full = 1'b0;
		end
		st = n + 1 - m;
		if (st > START_CAP)
			st = START_CAP;
		h.hash = HASH_W'(win_hash);
		h.start = START_W'(st);
		h.full = full;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [BYTE_W-1:0] pick_byte();
		if (alpha_n == 0 || $urandom_range(0, 9) == 0)
			return BYTE_W'($urandom);
		return alpha[$urandom_range(0, alpha_n - 1)];
	endfunction

	task automatic send(input search_item_t it, input bit lit, input hit_t lit_hit);
		int gap;
		hit_t h;
		bit got;
		cfg_ch.valid <= 1'b0;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= it.op;
		in_ch.byte_value <= it.value;
		in_ch.starts_over <= it.restart;
		do @(posedge clk); while (!in_ch.ready);
		got = roll_and_match(it, h);
		if (lit)
			pending_hits.push_back(lit_hit);
		else if (got)
			pending_hits.push_back(h);
		busy = 1'b1;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		int gap;
		in_ch.valid <= 1'b0;
		// an item with no result may still be in work
		if (busy) begin
			while (pending_hits.size() != 0) @(posedge clk);
			repeat (IDLE_CYCLES) @(posedge clk);
			busy = 1'b0;
		end
		gap = pick_gap();
		if (gap > 0) begin
			cfg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_MODULUS)
			mod_reg = data[Q_W-1:0];
		else
			len_reg = data[LEN_W-1:0];
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ch.ready <= 1'b1;
			if (run_left > 0) begin
				run_left <= run_left - 1;
			end else begin
				stall_left <= pick_gap();
				run_left <= $urandom_range(0, 15);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_hits.size() == 0) begin
				$error("unexpected result: hash_value %0d window_start %0d full_match %0d",
					$signed(out_ch.hash_value), out_ch.window_start, out_ch.full_match);
				err_cnt++;
			end else begin
				want = pending_hits.pop_front();
				if (out_ch.hash_value !== want.hash) begin
					$error("hash_value: expected %0d, got %0d",
						$signed(want.hash), $signed(out_ch.hash_value));
					err_cnt++;
				end
				if (out_ch.window_start !== want.start) begin
					$error("window_start: expected %0d, got %0d", want.start, out_ch.window_start);
					err_cnt++;
				end
				if (out_ch.full_match !== want.full) begin
					$error("full_match: expected %0d, got %0d", want.full, out_ch.full_match);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cnt <= 0;
			end else if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end else begin
				idle_cnt <= idle_cnt + 1;
			end
		end
	end

	initial begin
		int rand_items;
		int pick;
		int m_now;
		int cnt;
		int txt_len;
		int ofs;
		int k;
		bit fresh;
		bit big_done;
		logic [Q_W-1:0] q_new;
		logic [LEN_W-1:0] len_new;
		logic signed [BYTE_W-1:0] v;
		bit signed [BYTE_W-1:0] pat_buf [DEF_MAX_PATTERN];
		search_item_t it;

		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.op <= OP_PATTERN;
		in_ch.byte_value <= '0;
		in_ch.starts_over <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_MODULUS;
		cfg_ch.data <= '0;
		mod_reg = RESET_MODULUS;
		len_reg = RESET_PATTERN_LENGTH;
		pat_hash = 0;
		win_hash = 0;
		pow_term = 1;
		pat_cnt = 0;
		txt_cnt = 0;
		ring_wr = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
			else
				send(dir_rows[i].it, dir_rows[i].lit, dir_rows[i].want);
		end

		rand_items = 0;
		big_done = 1'b0;
		while (rand_items < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 8)
				q_new = Q_W'($urandom_range(0, 2));
			else if (pick < 20)
				q_new = 8'd255;
			else if (pick < 75)
				q_new = Q_W'($urandom_range(2, 31));
			else
				q_new = Q_W'($urandom_range(32, 254));
			pick = $urandom_range(0, 99);
			if ((pick < 4 || rand_items > RANDOM_ITEMS / 2) && !big_done) begin
				len_new = $urandom_range(0, 1) ? 9'd256 : LEN_W'($urandom_range(257, 511));
				big_done = 1'b1;
			end else if (pick < 8) begin
				len_new = '0;
			end else if (pick < 20) begin
				len_new = LEN_W'($urandom_range(7, 40));
			end else begin
				len_new = LEN_W'($urandom_range(1, 6));
			end
			// mostly both registers, sometimes only one so the other carries over
			pick = $urandom_range(0, 9);
			if (pick != 0)
				write_reg(REG_MODULUS, CFG_DATA_W'(q_new));
			if (pick != 1)
				write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len_new));
			m_now = (len_reg == 0) ? 1 :
				((len_reg > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : int'(len_reg));

			alpha_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 4);
			foreach (alpha[i])
				alpha[i] = BYTE_W'($urandom);

			pick = $urandom_range(0, 19);
			if (pick < 17) begin
				cnt = (pick >= 15 && m_now > 1) ? $urandom_range(1, m_now - 1) : m_now;
				for (k = 0; k < cnt; k++) begin
					pat_buf[k] = pick_byte();
					it = '{OP_PATTERN, pat_buf[k], k == 0};
					send(it, 1'b0, '0);
				end
				rand_items += cnt;
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						it = '{OP_PATTERN, pick_byte(), 1'b0};
						send(it, 1'b0, '0);
					end
				end
			end

			txt_len = m_now + ((m_now > 40) ? $urandom_range(2, 8) : $urandom_range(4, 30));
			ofs = ($urandom_range(0, 9) < 6) ? $urandom_range(0, txt_len - m_now) : -1;
			fresh = ($urandom_range(0, 7) != 0);
			for (k = 0; k < txt_len; k++) begin
				if ($urandom_range(0, 39) == 0) begin
					it = '{OP_PATTERN, pick_byte(), 1'($urandom_range(0, 1))};
					send(it, 1'b0, '0);
				end
				if (ofs >= 0 && k >= ofs && k < ofs + m_now)
					v = pat_buf[k - ofs];
				else
					v = pick_byte();
				it = '{OP_TEXT, v, (k == 0) && fresh};
				send(it, 1'b0, '0);
			end
			rand_items += txt_len;
		end

		// one long text to saturate the position counters
		quiet = 1'b0;
		write_reg(REG_MODULUS, CFG_DATA_W'(3));
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(2));
		alpha_n = 2;
		alpha[0] = BYTE_W'($urandom);
		alpha[1] = ~alpha[0];
		for (k = 0; k < 2; k++) begin
			it = '{OP_PATTERN, pick_byte(), k == 0};
			send(it, 1'b0, '0);
		end
		for (k = 0; k < LONG_TEXT; k++) begin
			it = '{OP_TEXT, pick_byte(), k == 0};
			send(it, 1'b0, '0);
		end

		in_ch.valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
